// ----- rtl/spaq_pkg.sv -----
// Shared types and constants for the sorted-array priority queue.
`default_nettype none
package spaq_pkg;

	localparam int DEF_CAPACITY = 8;
	localparam int VAL_W        = 32;

	// operation codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DELETE = 1'b1;

	// result status codes
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// operation broadcast to every cell of the chain
	typedef struct packed {
		logic                    do_ins;
		logic                    do_del;
		logic signed [VAL_W-1:0] ins_val;
	} cell_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/spaq_cell.sv -----
// One slot of the sorted chain: holds a value, shifts right on insert, left on delete.
`default_nettype none
module spaq_cell (
	input  wire                              clk,
	input  wire spaq_pkg::cell_ctrl_t        ctrl,
	input  wire                              occupied,
	input  wire                              is_tail,
	input  wire                              left_gt,
	input  wire signed [spaq_pkg::VAL_W-1:0] left_val,
	input  wire signed [spaq_pkg::VAL_W-1:0] right_val,
	output logic                             gt,
	output logic signed [spaq_pkg::VAL_W-1:0] val
);
	import spaq_pkg::*;

	logic signed [VAL_W-1:0] val_q;

	assign val = val_q;
	// stored value sits after the new one in sorted order
	assign gt  = occupied && (val_q > ctrl.ins_val);

	// insert: take left neighbor if it moves right, else new value if it lands here
	always_ff @(posedge clk) begin
		if (ctrl.do_ins) begin
			if (left_gt) begin
				val_q <= left_val;
			end else if (gt || is_tail) begin
				val_q <= ctrl.ins_val;
			end
		end else if (ctrl.do_del) begin
			val_q <= right_val;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/sorted_array_priority_queue_top.sv -----
// Top level of the sorted-array priority queue: chain of cells plus count and result registers.
//
// Bounded ascending priority queue of CAPACITY signed 32-bit values kept sorted in a
// row of cells. start with busy low transfers one operation (opcode 0 insert value_in,
// opcode 1 remove smallest). All cells compare against the new value in parallel and
// shift in the same edge, so busy stays low and a new operation may be issued every
// cycle. The result appears on the result ports with done high for exactly one cycle,
// the cycle after the transfer; the receiver cannot stall it, so it must capture the
// result in that cycle. Equal values keep arrival order. entry_count is the low four
// bits of the occupancy.
`default_nettype none
module sorted_array_priority_queue_top #(
	parameter int CAPACITY = spaq_pkg::DEF_CAPACITY
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	output logic                             busy,
	input  wire                              opcode,
	input  wire signed [spaq_pkg::VAL_W-1:0] value_in,
	output logic                             done,
	output logic signed [spaq_pkg::VAL_W-1:0] value_out,
	output logic                             value_valid,
	output logic [1:0]                       status,
	output logic [3:0]                       entry_count,
	output logic                             is_full,
	output logic                             is_empty
);
	import spaq_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int EXT_W = (CNT_W > 4) ? CNT_W : 4;
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        count_nxt;
	logic                    accept;
	logic                    q_full;
	logic                    q_empty;
	cell_ctrl_t              ctrl;
	logic [1:0]              st_nxt;

	logic                    gt_w   [CAPACITY];
	logic signed [VAL_W-1:0] val_w  [CAPACITY];

	logic                    done_q;
	logic signed [VAL_W-1:0] value_out_q;
	logic                    value_valid_q;
	logic [1:0]              status_q;
	logic [CNT_W-1:0]        count_out_q;
	logic [EXT_W-1:0]        count_ext;

	assign busy    = 1'b0;
	assign accept  = start && !busy;
	assign q_full  = (count_q == CAP_CNT);
	assign q_empty = (count_q == '0);

	// decode the operation and its effect on the count
	always_comb begin
		ctrl.ins_val = value_in;
		ctrl.do_ins  = 1'b0;
		ctrl.do_del  = 1'b0;
		st_nxt       = ST_DONE;
		count_nxt    = count_q;
		if (accept) begin
			if (opcode == OP_INSERT) begin
				if (q_full) begin
					st_nxt = ST_FULL;
				end else begin
					ctrl.do_ins = 1'b1;
					count_nxt   = count_q + CNT_W'(1);
				end
			end else begin
				if (q_empty) begin
					st_nxt = ST_EMPTY;
				end else begin
					ctrl.do_del = 1'b1;
					count_nxt   = count_q - CNT_W'(1);
				end
			end
		end
	end

	// the chain of cells, slot 0 holds the smallest value
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                    left_gt;
		logic signed [VAL_W-1:0] left_val;
		logic signed [VAL_W-1:0] right_val;

		if (i == 0) begin : g_head
			assign left_gt  = 1'b0;
			assign left_val = '0;
		end else begin : g_mid
			assign left_gt  = gt_w[i-1];
			assign left_val = val_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_val = val_w[i];
		end else begin : g_body
			assign right_val = val_w[i+1];
		end

		spaq_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.occupied  (CNT_W'(i) < count_q),
			.is_tail   (CNT_W'(i) == count_q),
			.left_gt   (left_gt),
			.left_val  (left_val),
			.right_val (right_val),
			.gt        (gt_w[i]),
			.val       (val_w[i])
		);
	end

	// occupancy and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_nxt;
			done_q  <= accept;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			value_out_q   <= ctrl.do_del ? val_w[0] : '0;
			value_valid_q <= ctrl.do_del;
			status_q      <= st_nxt;
			count_out_q   <= count_nxt;
		end
	end

	assign count_ext   = EXT_W'(count_out_q);
	assign done        = done_q;
	assign value_out   = value_out_q;
	assign value_valid = value_valid_q;
	assign status      = status_q;
	assign entry_count = count_ext[3:0];
	assign is_full     = (count_out_q == CAP_CNT);
	assign is_empty    = (count_out_q == '0);

endmodule
`default_nettype wire

// ----- tb/sorted_array_priority_queue_top_tb.sv -----
// Self-checking testbench for the sorted-array priority queue: predictor, scoreboard, stimulus.
`default_nettype none

typedef struct packed {
	logic signed [spaq_pkg::VAL_W-1:0] value;
	logic                              valid;
	logic [1:0]                        status;
	logic [3:0]                        count;
	logic                              full;
	logic                              empty;
} pq_result_t;

// Scoreboard: keeps its own sorted copy of the queue and the results still owed.
class pq_scoreboard;
	localparam int CAP = spaq_pkg::DEF_CAPACITY;

	logic signed [spaq_pkg::VAL_W-1:0] slots [CAP];
	int unsigned                       fill;
	pq_result_t                        owed_q [$];
	int unsigned                       failures;

	function new();
		fill     = 0;
		failures = 0;
	endfunction

	function int unsigned pending();
		return owed_q.size();
	endfunction

	// Work out the result of one accepted operation and update the queue copy.
	function void note_transfer(logic op, logic signed [spaq_pkg::VAL_W-1:0] val);
		pq_result_t  want;
		int unsigned i;
		want = '0;
		want.status = spaq_pkg::ST_DONE;
		if (op == spaq_pkg::OP_INSERT) begin
			if (fill >= CAP) begin
				want.status = spaq_pkg::ST_FULL;
			end else begin
				// shift larger entries up; equal values stay ahead of the new one
				i = fill;
				while (i > 0 && slots[i-1] > val) begin
					slots[i] = slots[i-1];
					i--;
				end
				slots[i] = val;
				fill++;
			end
		end else begin
			if (fill == 0) begin
				want.status = spaq_pkg::ST_EMPTY;
			end else begin
				want.value = slots[0];
				want.valid = 1'b1;
				for (i = 1; i < fill; i++)
					slots[i-1] = slots[i];
				fill--;
			end
		end
		want.count = 4'(fill);
		want.full  = (fill == CAP);
		want.empty = (fill == 0);
		owed_q.push_back(want);
	endfunction

	// Compare one result strobe against the oldest owed result.
	function void check_result(pq_result_t got);
		pq_result_t want;
		if (owed_q.size() == 0) begin
			failures++;
			if (failures <= 10)
				$display("ERROR %0t: unexpected result value=%0d status=%0d count=%0d",
					$time, got.value, got.status, got.count);
			return;
		end
		want = owed_q.pop_front();
		if (got.value !== want.value || got.valid !== want.valid ||
				got.status !== want.status || got.count !== want.count ||
				got.full !== want.full || got.empty !== want.empty) begin
			failures++;
			if (failures <= 10) begin
				$display("ERROR %0t: result mismatch", $time);
				$display("  expected value=%0d valid=%b status=%0d count=%0d full=%b empty=%b",
					want.value, want.valid, want.status, want.count, want.full, want.empty);
				$display("  actual   value=%0d valid=%b status=%0d count=%0d full=%b empty=%b",
					got.value, got.valid, got.status, got.count, got.full, got.empty);
			end
		end
	endfunction
endclass

module sorted_array_priority_queue_top_tb;
	import spaq_pkg::*;

	localparam int          CAP       = DEF_CAPACITY;
	localparam int unsigned MAX_CYCLES = 200000;
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic                    opcode;
	logic signed [VAL_W-1:0] value_in;
	logic                    done;
	logic signed [VAL_W-1:0] value_out;
	logic                    value_valid;
	logic [1:0]              status;
	logic [3:0]              entry_count;
	logic                    is_full;
	logic                    is_empty;

	pq_scoreboard sb;
	int unsigned  cycles;

	sorted_array_priority_queue_top #(.CAPACITY(CAP)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.opcode     (opcode),
		.value_in   (value_in),
		.done       (done),
		.value_out  (value_out),
		.value_valid(value_valid),
		.status     (status),
		.entry_count(entry_count),
		.is_full    (is_full),
		.is_empty   (is_empty)
	);

	// clock, period 8
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > MAX_CYCLES) begin
			$display("FAILURE");
			$finish;
		end
	end

	// monitor: note each accepted transfer, then check any result strobe
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_transfer(opcode, value_in);
			if (done)
				sb.check_result({value_out, value_valid, status, entry_count, is_full, is_empty});
		end
	end

	// Drive one operation after a gap; returns at the edge that accepts it.
	task automatic send_op(input logic op, input logic signed [VAL_W-1:0] val,
			input int unsigned gap);
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start    <= 1'b1;
		opcode   <= op;
		value_in <= val;
		do @(posedge clk); while (busy);
	endtask

	// Drop start and wait until every owed result has come back.
	task automatic drain_queue();
		@(negedge clk);
		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Mix of extremes, a narrow band for duplicates, and full-range values.
	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return VAL_MIN;
			1:       return VAL_MAX;
			2, 3:    return $signed(VAL_W'($urandom_range(0, 8))) - 4;
			default: return $signed($urandom);
		endcase
	endfunction

	initial begin
		int unsigned blk;
		int unsigned n;
		int unsigned ins_pct;
		bit          gaps_on;
		logic        op;

		sb       = new();
		cycles   = 0;
		arst_n   = 1'b0;
		start    = 1'b0;
		opcode   = OP_INSERT;
		value_in = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: delete while empty, extremes and duplicates, fill, insert while full
		send_op(OP_DELETE, VAL_MAX, 1);
		send_op(OP_INSERT, VAL_MAX, 0);
		send_op(OP_INSERT, VAL_MIN, 0);
		send_op(OP_INSERT, 0, 0);
		send_op(OP_INSERT, -1, 2);
		send_op(OP_INSERT, 0, 0);
		send_op(OP_INSERT, 1, 0);
		send_op(OP_INSERT, 32'sh5555_5555, 0);
		send_op(OP_INSERT, 32'shAAAA_AAAA, 0);
		send_op(OP_INSERT, 7, 0);
		send_op(OP_INSERT, VAL_MIN, 3);
		// empty it out, then one more delete
		for (n = 0; n < CAP + 1; n++)
			send_op(OP_DELETE, $signed($urandom), n % 2);
		drain_queue();

		// random blocks with varying insert/delete balance to swing between full and empty
		for (blk = 0; blk < 20; blk++) begin
			case ($urandom_range(0, 4))
				0:       ins_pct = 90;
				1:       ins_pct = 70;
				2:       ins_pct = 50;
				3:       ins_pct = 30;
				default: ins_pct = 10;
			endcase
			gaps_on = ($urandom_range(0, 3) != 0);
			for (n = 0; n < 100; n++) begin
				op = ($urandom_range(1, 100) <= ins_pct) ? OP_INSERT : OP_DELETE;
				send_op(op, pick_value(), gaps_on ? $urandom_range(0, 7) : 0);
			end
			// hold off until the queue has answered everything
			if (blk % 4 == 3)
				drain_queue();
		end

		drain_queue();
		repeat (4) @(posedge clk);
		if (sb.failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
`default_nettype wire

// ----- sim.f -----
rtl/spaq_pkg.sv
rtl/spaq_cell.sv
rtl/sorted_array_priority_queue_top.sv
tb/sorted_array_priority_queue_top_tb.sv
